FILE: rtl/core/ktn_pkg.sv
// Shared widths, codes, defaults and the sequencer state type for the k-ary tree neighbor block.
package ktn_pkg;

    localparam int PE_W    = 10;
    localparam int SIZE_W  = 11;
    localparam int RADIX_W = 4;
    localparam int COUNT_W = 4;

    localparam int DEF_MAX_PES   = 1024;
    localparam int DEF_MAX_RADIX = 8;

    localparam logic ROLE_PARENT = 1'b0;
    localparam logic ROLE_CHILD  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_POS,
        ST_RANK,
        ST_DIV_RANK,
        ST_PIDX,
        ST_KIDS,
        ST_MUL_PAR,
        ST_EMIT_PAR,
        ST_MUL_KID,
        ST_EMIT_KID
    } ktn_state_t;

endpackage

FILE: rtl/core/ktn_ifs.sv
// Valid/ready channel interfaces for tree queries and neighbor results.
interface ktn_query_if
    import ktn_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [RADIX_W-1:0] tree_radix;
    logic [PE_W-1:0]    set_start;
    logic [PE_W-1:0]    set_stride;
    logic [SIZE_W-1:0]  set_size;
    logic [PE_W-1:0]    root_index;

    modport source (
        output valid, tree_radix, set_start, set_stride, set_size, root_index,
        input  ready
    );
    modport sink (
        input  valid, tree_radix, set_start, set_stride, set_size, root_index,
        output ready
    );
endinterface

interface ktn_result_if
    import ktn_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               role;
    logic [PE_W-1:0]    pe_number;
    logic [COUNT_W-1:0] child_count;
    logic               last;

    modport source (
        output valid, role, pe_number, child_count, last,
        input  ready
    );
    modport sink (
        input  valid, role, pe_number, child_count, last,
        output ready
    );
endinterface

FILE: rtl/core/kary_tree_neighbors.sv
// K-ary tree neighbor finder: parent and children of this element for a strided set.
//
// A request on the query channel gives a strided set, a root position and a radix.
// The user writes the element number own_pe through cfg_wr_en/cfg_wr_data only
// while idle; the block does not enforce this. The block answers with one parent
// result, then one result per child in rank order, on the result channel; last
// marks the final result. A request whose fields are out of range, or for which
// this element is not a set member, produces no result.
// The position comes from one bit-serial divider pass (skipped for a zero stride),
// the parent rank from another (skipped at the root); the rank, parent-index and
// child-count steps and one bit-serial multiply then put the parent result in the
// output register. The first child takes another multiply and its emit step; each
// further child is formed by adding the stride and is emitted once the output
// register is free. One request is worked at a time; a new one is taken once the
// last result is in the output register.
// Reset clears the sequencer, the output valid and own_pe. A stalled receiver
// holds the output register and the sequencer waits before the next result.
module kary_tree_neighbors
    import ktn_pkg::*;
#(
    parameter int MAX_PES   = DEF_MAX_PES,
    parameter int MAX_RADIX = DEF_MAX_RADIX
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [PE_W-1:0]   cfg_wr_data,
    ktn_query_if.sink         query,
    ktn_result_if.source      result
);

    localparam int DIV_W = SIZE_W;
    localparam int KID_W = RADIX_W + SIZE_W + 1;
    localparam int CNT_W = $clog2(DIV_W + 1);

    ktn_state_t state_reg, state_next;

    logic [PE_W-1:0]    own_pe_reg;
    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic [PE_W-1:0]    start_reg, start_next;
    logic [PE_W-1:0]    stride_reg, stride_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [PE_W-1:0]    root_reg, root_next;
    logic [SIZE_W-1:0]  rank_reg, rank_next;
    logic [SIZE_W-1:0]  pidx_reg, pidx_next;
    logic [KID_W-1:0]   base_reg, base_next;
    logic [COUNT_W-1:0] nkids_reg, nkids_next;
    logic [COUNT_W-1:0] kid_left_reg, kid_left_next;
    logic [SIZE_W-1:0]  kid_idx_reg, kid_idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_W-1:0]   div_rem_reg, div_rem_next;
    logic [DIV_W-1:0]   div_quo_reg, div_quo_next;
    logic [DIV_W-1:0]   div_den_reg, div_den_next;
    logic [PE_W-1:0]    mul_acc_reg, mul_acc_next;
    logic [PE_W-1:0]    mul_cand_reg, mul_cand_next;
    logic [PE_W-1:0]    mul_plier_reg, mul_plier_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_role_reg, out_role_next;
    logic [PE_W-1:0]    out_pe_reg, out_pe_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_last_reg, out_last_next;

    logic               query_ok;
    logic               accept;
    logic               out_free;
    logic [DIV_W:0]     div_trial;
    logic               div_ge;
    logic [DIV_W-1:0]   div_rem_step;
    logic [DIV_W-1:0]   div_quo_step;
    logic               div_done;
    logic               mul_done;
    logic [PE_W-1:0]    mul_acc_step;
    logic               pos_ok;
    logic [SIZE_W:0]    rank_sum;
    logic [SIZE_W-1:0]  rank_val;
    logic [SIZE_W:0]    pidx_sum;
    logic               no_kids;
    logic [SIZE_W-1:0]  kid_avail;
    logic [SIZE_W:0]    kid_sum;
    logic [SIZE_W:0]    kid_inc;
    logic               kid_wrap;

    assign query.ready   = (state_reg == ST_IDLE);
    assign accept        = query.valid && query.ready;
    assign out_free      = !out_valid_reg || result.ready;

    assign query_ok = (query.tree_radix >= RADIX_W'(2))
                   && (int'(query.tree_radix) <= MAX_RADIX)
                   && (query.set_size != '0)
                   && (int'(query.set_size) <= MAX_PES)
                   && ({1'b0, query.root_index} < query.set_size)
                   && (own_pe_reg >= query.set_start)
                   && ((query.set_stride != '0) || (own_pe_reg == query.set_start));

    // restoring divider, one quotient bit per cycle
    assign div_trial    = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign div_ge       = div_trial >= {1'b0, div_den_reg};
    assign div_rem_step = div_ge ? DIV_W'(div_trial - {1'b0, div_den_reg})
                                 : div_trial[DIV_W-1:0];
    assign div_quo_step = {div_quo_reg[DIV_W-2:0], div_ge};
    assign div_done     = (cnt_reg == CNT_W'(DIV_W - 1));

    // shift-add multiplier, result kept modulo the element field
    assign mul_acc_step = mul_acc_reg + (mul_plier_reg[0] ? mul_cand_reg : '0);
    assign mul_done     = (cnt_reg == CNT_W'(PE_W - 1));

    assign pos_ok   = div_quo_reg < size_reg;
    assign rank_sum = {1'b0, div_quo_reg} + {1'b0, size_reg} - (SIZE_W+1)'(root_reg);
    assign rank_val = (rank_sum >= {1'b0, size_reg}) ? SIZE_W'(rank_sum - {1'b0, size_reg})
                                                     : rank_sum[SIZE_W-1:0];
    assign pidx_sum = {1'b0, div_quo_reg} + (SIZE_W+1)'(root_reg);

    assign no_kids   = base_reg >= KID_W'(size_reg);
    assign kid_avail = size_reg - base_reg[SIZE_W-1:0];
    assign kid_sum   = (SIZE_W+1)'(root_reg) + {1'b0, base_reg[SIZE_W-1:0]};
    assign kid_inc   = {1'b0, kid_idx_reg} + (SIZE_W+1)'(1);
    assign kid_wrap  = (kid_inc == {1'b0, size_reg});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && query_ok)
                begin
                    state_next = (query.set_stride == '0) ? ST_RANK : ST_DIV_POS;
                end
            end
            ST_DIV_POS:
            begin
                if (div_done)
                begin
                    state_next = (div_rem_step != '0) ? ST_IDLE : ST_RANK;
                end
            end
            ST_RANK:
            begin
                if (!pos_ok)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = (rank_val == '0) ? ST_PIDX : ST_DIV_RANK;
                end
            end
            ST_DIV_RANK:
            begin
                if (div_done)
                begin
                    state_next = ST_PIDX;
                end
            end
            ST_PIDX:     state_next = ST_KIDS;
            ST_KIDS:     state_next = ST_MUL_PAR;
            ST_MUL_PAR:
            begin
                if (mul_done)
                begin
                    state_next = ST_EMIT_PAR;
                end
            end
            ST_EMIT_PAR:
            begin
                if (out_free)
                begin
                    state_next = (nkids_reg == '0) ? ST_IDLE : ST_MUL_KID;
                end
            end
            ST_MUL_KID:
            begin
                if (mul_done)
                begin
                    state_next = ST_EMIT_KID;
                end
            end
            ST_EMIT_KID:
            begin
                if (out_free && (kid_left_reg == COUNT_W'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        radix_next     = radix_reg;
        start_next     = start_reg;
        stride_next    = stride_reg;
        size_next      = size_reg;
        root_next      = root_reg;
        rank_next      = rank_reg;
        pidx_next      = pidx_reg;
        base_next      = base_reg;
        nkids_next     = nkids_reg;
        kid_left_next  = kid_left_reg;
        kid_idx_next   = kid_idx_reg;
        cnt_next       = cnt_reg + CNT_W'(1);
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_den_next   = div_den_reg;
        mul_acc_next   = mul_acc_reg;
        mul_cand_next  = mul_cand_reg;
        mul_plier_next = mul_plier_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_role_next  = out_role_reg;
        out_pe_next    = out_pe_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                radix_next   = query.tree_radix;
                start_next   = query.set_start;
                stride_next  = query.set_stride;
                size_next    = query.set_size;
                root_next    = query.root_index;
                cnt_next     = '0;
                div_rem_next = '0;
                div_quo_next = (query.set_stride == '0) ? '0
                             : DIV_W'(own_pe_reg - query.set_start);
                div_den_next = DIV_W'(query.set_stride);
            end
            ST_DIV_POS, ST_DIV_RANK:
            begin
                div_rem_next = div_rem_step;
                div_quo_next = div_quo_step;
            end
            ST_RANK:
            begin
                rank_next    = rank_val;
                cnt_next     = '0;
                div_rem_next = '0;
                div_quo_next = (rank_val == '0) ? '0 : rank_val - SIZE_W'(1);
                div_den_next = DIV_W'(radix_reg);
            end
            ST_PIDX:
            begin
                pidx_next = (pidx_sum >= {1'b0, size_reg}) ? SIZE_W'(pidx_sum - {1'b0, size_reg})
                                                           : pidx_sum[SIZE_W-1:0];
                base_next = KID_W'(radix_reg) * KID_W'(rank_reg) + KID_W'(1);
            end
            ST_KIDS:
            begin
                if (no_kids)
                begin
                    nkids_next = '0;
                end
                else if (kid_avail >= SIZE_W'(radix_reg))
                begin
                    nkids_next = COUNT_W'(radix_reg);
                end
                else
                begin
                    nkids_next = kid_avail[COUNT_W-1:0];
                end
                kid_left_next  = nkids_next;
                kid_idx_next   = (kid_sum >= {1'b0, size_reg}) ? SIZE_W'(kid_sum - {1'b0, size_reg})
                                                               : kid_sum[SIZE_W-1:0];
                cnt_next       = '0;
                mul_acc_next   = start_reg;
                mul_cand_next  = stride_reg;
                mul_plier_next = pidx_reg[PE_W-1:0];
            end
            ST_MUL_PAR, ST_MUL_KID:
            begin
                mul_acc_next   = mul_acc_step;
                mul_cand_next  = {mul_cand_reg[PE_W-2:0], 1'b0};
                mul_plier_next = {1'b0, mul_plier_reg[PE_W-1:1]};
            end
            ST_EMIT_PAR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_role_next  = ROLE_PARENT;
                    out_pe_next    = mul_acc_reg;
                    out_count_next = nkids_reg;
                    out_last_next  = (nkids_reg == '0);
                    cnt_next       = '0;
                    mul_acc_next   = start_reg;
                    mul_cand_next  = stride_reg;
                    mul_plier_next = kid_idx_reg[PE_W-1:0];
                end
            end
            ST_EMIT_KID:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_role_next  = ROLE_CHILD;
                    out_pe_next    = mul_acc_reg;
                    out_count_next = nkids_reg;
                    out_last_next  = (kid_left_reg == COUNT_W'(1));
                    kid_left_next  = kid_left_reg - COUNT_W'(1);
                    // next child rank: step one stride, or back to start on wrap
                    kid_idx_next   = kid_wrap ? '0 : kid_inc[SIZE_W-1:0];
                    mul_acc_next   = kid_wrap ? start_reg : mul_acc_reg + stride_reg;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            own_pe_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                own_pe_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        radix_reg     <= radix_next;
        start_reg     <= start_next;
        stride_reg    <= stride_next;
        size_reg      <= size_next;
        root_reg      <= root_next;
        rank_reg      <= rank_next;
        pidx_reg      <= pidx_next;
        base_reg      <= base_next;
        nkids_reg     <= nkids_next;
        kid_left_reg  <= kid_left_next;
        kid_idx_reg   <= kid_idx_next;
        cnt_reg       <= cnt_next;
        div_rem_reg   <= div_rem_next;
        div_quo_reg   <= div_quo_next;
        div_den_reg   <= div_den_next;
        mul_acc_reg   <= mul_acc_next;
        mul_cand_reg  <= mul_cand_next;
        mul_plier_reg <= mul_plier_next;
        out_role_reg  <= out_role_next;
        out_pe_reg    <= out_pe_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.role        = out_role_reg;
    assign result.pe_number   = out_pe_reg;
    assign result.child_count = out_count_reg;
    assign result.last        = out_last_reg;

endmodule
